@@ design/ticf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ticf_pkg: shared types and constants for the track isolation cone filter
// Field widths, request kinds, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package ticf_pkg;

  localparam int MAX_OWN_TRACKS_DEF = 8;

  localparam int IDX_W   = 12;
  localparam int ETA_W   = 13;
  localparam int PHI_W   = 13;
  localparam int Z0_W    = 12;
  localparam int PT_W    = 14;
  localparam int RAD_W   = 12;
  localparam int GAP_W   = 12;
  localparam int SUM_W   = 20;
  localparam int FUNC_W  = 2;

  localparam int DIFF_W  = 14;             // eta/phi difference, signed
  localparam int DZ_W    = 13;             // z0 difference, signed
  localparam int SQ_W    = 2 * DIFF_W;     // one squared term
  localparam int DR2_W   = SQ_W + 1;       // sum of two squared terms
  localparam int RSQ_W   = 2 * RAD_W;      // squared radius

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int IN_DATA_W  = 64;          // 12+13+13+12+14
  localparam int OUT_DATA_W = 40;          // 1+1+12+20 = 34, padded

  localparam int PHI_PI     = 3217;
  localparam int PHI_TWO_PI = 6434;

  localparam logic [GAP_W-1:0] GAP_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_TEST  = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEAD_ETA    = 3'd0,
    REG_LEAD_PHI    = 3'd1,
    REG_LEAD_Z0     = 3'd2,
    REG_CONE_INNER  = 3'd3,
    REG_CONE_OUTER  = 3'd4,
    REG_Z0_GAP_MAX  = 3'd5,
    REG_EXCLUDE_OWN = 3'd6
  } reg_idx_t;

endpackage

@@ design/track_isolation_cone_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_isolation_cone_filter: annulus track isolation for one tau candidate
// Own-track exclusion, eta/phi annulus test, running min z0 gap and pt sum.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_tready is high; each test request
// gives one result on out_tvalid once it reaches the output register, and
// start, load and unused requests give no result. The pipeline is input register, difference stage (own-set
// match, phi wrap, absolute values), squaring stage, then the annulus compare
// and the running min-gap / pt-sum update feeding the output register. Every
// stage holds its item only while the stage ahead is full, so a waiting
// result does not block new requests until the pipe fills. Radii are squared
// when they are written. Write configuration only while the pipe is empty.
// ----------------------------------------------------------------------------
module track_isolation_cone_filter #(
  parameter int MAX_OWN_TRACKS = ticf_pkg::MAX_OWN_TRACKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write port
  input  logic                            cfg_we,
  input  logic [ticf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ticf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // request channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: track_index[11:0], track_eta[24:12], track_phi[37:25],
  //        track_z0[49:38], track_pt[63:50]
  input  logic [ticf_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: func[1:0]
  input  logic [ticf_pkg::FUNC_W-1:0]     in_tuser,
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: in_cone[0], was_excluded[1], min_z0_gap[13:2], pt_sum[33:14],
  //        zero pad [39:34]
  output logic [ticf_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ticf_pkg::*;

  localparam int CNT_W  = $clog2(MAX_OWN_TRACKS + 1);
  localparam int SLOT_W = (MAX_OWN_TRACKS > 1) ? $clog2(MAX_OWN_TRACKS) : 1;

  // config registers
  logic signed [ETA_W-1:0] lead_eta_r;
  logic signed [PHI_W-1:0] lead_phi_r;
  logic signed [Z0_W-1:0]  lead_z0_r;
  logic [RSQ_W-1:0]        rin2_r;
  logic [RSQ_W-1:0]        rout2_r;
  logic [GAP_W-1:0]        z0_gap_max_r;
  logic                    exclude_own_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_eta_r    <= '0;
      lead_phi_r    <= '0;
      lead_z0_r     <= '0;
      rin2_r        <= '0;
      rout2_r       <= '0;
      z0_gap_max_r  <= GAP_MAX;
      exclude_own_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEAD_ETA:    lead_eta_r    <= cfg_wdata[ETA_W-1:0];
        REG_LEAD_PHI:    lead_phi_r    <= cfg_wdata[PHI_W-1:0];
        REG_LEAD_Z0:     lead_z0_r     <= cfg_wdata[Z0_W-1:0];
        REG_CONE_INNER:  rin2_r        <= RSQ_W'(cfg_wdata[RAD_W-1:0]) *
                                          RSQ_W'(cfg_wdata[RAD_W-1:0]);
        REG_CONE_OUTER:  rout2_r       <= RSQ_W'(cfg_wdata[RAD_W-1:0]) *
                                          RSQ_W'(cfg_wdata[RAD_W-1:0]);
        REG_Z0_GAP_MAX:  z0_gap_max_r  <= cfg_wdata[GAP_W-1:0];
        REG_EXCLUDE_OWN: exclude_own_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // flow control: a stage takes a new item when empty or when it moves on
  logic v1_r, v2_r, v3_r, out_tvalid_r;
  logic slot1, slot2, slot3, take1, take3;

  assign slot3     = !out_tvalid_r || out_tready;
  assign slot2     = !v3_r || slot3;
  assign slot1     = !v2_r || slot2;
  assign in_tready = !v1_r || slot1;
  assign take1     = v1_r && slot1;
  assign take3     = v3_r && slot3;

  // stage 1: input register
  func_t                   func1_r;
  logic [IDX_W-1:0]        idx1_r;
  logic signed [ETA_W-1:0] eta1_r;
  logic signed [PHI_W-1:0] phi1_r;
  logic signed [Z0_W-1:0]  z01_r;
  logic [PT_W-1:0]         pt1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      func1_r <= func_t'(in_tuser);
      idx1_r  <= in_tdata[11:0];
      eta1_r  <= in_tdata[24:12];
      phi1_r  <= in_tdata[37:25];
      z01_r   <= in_tdata[49:38];
      pt1_r   <= in_tdata[63:50];
    end
  end

  // own track set, written by load requests as they leave stage 1
  logic [IDX_W-1:0] own_r [MAX_OWN_TRACKS];
  logic [CNT_W-1:0] own_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_count_r <= '0;
    end else if (take1) begin
      case (func1_r)
        FUNC_START: own_count_r <= '0;
        FUNC_LOAD: begin
          if (own_count_r < CNT_W'(MAX_OWN_TRACKS)) begin
            own_count_r <= own_count_r + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take1 && func1_r == FUNC_LOAD && own_count_r < CNT_W'(MAX_OWN_TRACKS)) begin
      own_r[own_count_r[SLOT_W-1:0]] <= idx1_r;
    end
  end

  // stage 1 logic: set match, differences, phi wrap, absolute values
  logic                     match1;
  logic signed [DIFF_W-1:0] deta1, dphi1, dphi1_w;
  logic signed [DZ_W-1:0]   dz1;
  logic [DIFF_W-1:0]        ae1, ap1;
  logic [DZ_W-1:0]          adz1;
  logic [GAP_W-1:0]         gap1;

  always_comb begin
    match1 = 1'b0;
    for (int i = 0; i < MAX_OWN_TRACKS; i++) begin
      if (CNT_W'(i) < own_count_r && own_r[i] == idx1_r) begin
        match1 = 1'b1;
      end
    end
    match1 = match1 && exclude_own_r;

    deta1 = DIFF_W'(eta1_r) - DIFF_W'(lead_eta_r);
    dphi1 = DIFF_W'(phi1_r) - DIFF_W'(lead_phi_r);
    if (dphi1 > DIFF_W'(PHI_PI)) begin
      dphi1_w = dphi1 - DIFF_W'(PHI_TWO_PI);
    end else if (dphi1 < -DIFF_W'(PHI_PI)) begin
      dphi1_w = dphi1 + DIFF_W'(PHI_TWO_PI);
    end else begin
      dphi1_w = dphi1;
    end
    ae1 = deta1[DIFF_W-1] ? DIFF_W'(-deta1) : DIFF_W'(deta1);
    ap1 = dphi1_w[DIFF_W-1] ? DIFF_W'(-dphi1_w) : DIFF_W'(dphi1_w);

    dz1  = DZ_W'(z01_r) - DZ_W'(lead_z0_r);
    adz1 = dz1[DZ_W-1] ? DZ_W'(-dz1) : DZ_W'(dz1);
    gap1 = adz1[DZ_W-1] ? GAP_MAX : adz1[GAP_W-1:0];
  end

  // stage 2: differences
  logic              test2_r, match2_r;
  logic [DIFF_W-1:0] ae2_r, ap2_r;
  logic [GAP_W-1:0]  gap2_r;
  logic [PT_W-1:0]   pt2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (slot1) begin
      v2_r <= v1_r && (func1_r == FUNC_START || func1_r == FUNC_TEST);
    end
  end

  always_ff @(posedge clk) begin
    if (take1) begin
      test2_r  <= (func1_r == FUNC_TEST);
      match2_r <= match1;
      ae2_r    <= ae1;
      ap2_r    <= ap1;
      gap2_r   <= gap1;
      pt2_r    <= pt1_r;
    end
  end

  // stage 3: squares
  logic             test3_r, match3_r;
  logic [SQ_W-1:0]  esq3_r, psq3_r;
  logic [GAP_W-1:0] gap3_r;
  logic [PT_W-1:0]  pt3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (slot2) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && slot2) begin
      test3_r  <= test2_r;
      match3_r <= match2_r;
      esq3_r   <= SQ_W'(ae2_r) * SQ_W'(ae2_r);
      psq3_r   <= SQ_W'(ap2_r) * SQ_W'(ap2_r);
      gap3_r   <= gap2_r;
      pt3_r    <= pt2_r;
    end
  end

  // stage 4: annulus compare and running results
  logic [GAP_W-1:0] min_gap_r, min_gap_nxt;
  logic [SUM_W-1:0] sum_pt_r, sum_pt_nxt;
  logic [DR2_W-1:0] dr2;
  logic [SUM_W:0]   sum_wide;
  logic             in_ring;

  always_comb begin
    dr2      = DR2_W'(esq3_r) + DR2_W'(psq3_r);
    in_ring  = !match3_r && (dr2 > DR2_W'(rin2_r)) && (dr2 < DR2_W'(rout2_r));
    sum_wide = {1'b0, sum_pt_r} + (SUM_W + 1)'(pt3_r);

    min_gap_nxt = min_gap_r;
    sum_pt_nxt  = sum_pt_r;
    if (!test3_r) begin
      min_gap_nxt = GAP_MAX;
      sum_pt_nxt  = '0;
    end else if (in_ring) begin
      if (gap3_r < min_gap_r) begin
        min_gap_nxt = gap3_r;
      end
      if (gap3_r <= z0_gap_max_r) begin
        sum_pt_nxt = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r <= GAP_MAX;
      sum_pt_r  <= '0;
    end else if (take3) begin
      min_gap_r <= min_gap_nxt;
      sum_pt_r  <= sum_pt_nxt;
    end
  end

  // output register
  logic [OUT_DATA_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (slot3) begin
      out_tvalid_r <= v3_r && test3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take3 && test3_r) begin
      out_tdata_r <= {(OUT_DATA_W - 2 - GAP_W - SUM_W)'(0),
                      sum_pt_nxt, min_gap_nxt, match3_r, in_ring};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
